[src/xbtp_pkg.sv]
// Package for the x86 branch target predecoder.
// Opcode constants, opcode classifiers and the result record type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package xbtp_pkg;

   localparam logic [7:0] OP_CALL      = 8'hE8;
   localparam logic [7:0] OP_JMP_NEAR  = 8'hE9;
   localparam logic [7:0] OP_JMP_SHORT = 8'hEB;
   localparam logic [7:0] OP_RET       = 8'hC3;
   localparam logic [7:0] OP_ESCAPE    = 8'h0F;

   // Jcc short forms
   localparam logic [7:0] OP_JB_S  = 8'h72;
   localparam logic [7:0] OP_JE_S  = 8'h74;
   localparam logic [7:0] OP_JNE_S = 8'h75;
   localparam logic [7:0] OP_JS_S  = 8'h78;
   localparam logic [7:0] OP_JNS_S = 8'h79;
   localparam logic [7:0] OP_JL_S  = 8'h7C;
   localparam logic [7:0] OP_JGE_S = 8'h7D;
   localparam logic [7:0] OP_JLE_S = 8'h7E;
   localparam logic [7:0] OP_JG_S  = 8'h7F;

   // Jcc near forms, second byte after 0F
   localparam logic [7:0] OP2_JB_N  = 8'h82;
   localparam logic [7:0] OP2_JE_N  = 8'h84;
   localparam logic [7:0] OP2_JNE_N = 8'h85;
   localparam logic [7:0] OP2_JS_N  = 8'h88;
   localparam logic [7:0] OP2_JNS_N = 8'h89;
   localparam logic [7:0] OP2_JL_N  = 8'h8C;
   localparam logic [7:0] OP2_JGE_N = 8'h8D;
   localparam logic [7:0] OP2_JLE_N = 8'h8E;
   localparam logic [7:0] OP2_JG_N  = 8'h8F;

   // Instruction lengths used for the target
   localparam logic [2:0] LEN_SHORT = 3'd2;
   localparam logic [2:0] LEN_CALL  = 3'd5;
   localparam logic [2:0] LEN_NEAR  = 3'd6;

   typedef struct packed {
      logic        is_flow_control;
      logic        target_valid;
      logic [63:0] target_addr;
      logic        fallthrough_valid;
      logic [63:0] fallthrough_addr;
   } rsp_type;

   function automatic logic is_near_jcc(input logic [7:0] sec);
      return (sec == OP2_JB_N)  || (sec == OP2_JE_N)  || (sec == OP2_JNE_N) ||
             (sec == OP2_JS_N)  || (sec == OP2_JNS_N) || (sec == OP2_JL_N)  ||
             (sec == OP2_JGE_N) || (sec == OP2_JLE_N) || (sec == OP2_JG_N);
   endfunction

   function automatic logic is_short_branch(input logic [7:0] op);
      return (op == OP_JMP_SHORT) || (op == OP_JB_S)  || (op == OP_JE_S)  ||
             (op == OP_JNE_S)     || (op == OP_JS_S)  || (op == OP_JNS_S) ||
             (op == OP_JL_S)      || (op == OP_JGE_S) || (op == OP_JLE_S) ||
             (op == OP_JG_S);
   endfunction

endpackage

`default_nettype wire

[src/x86_branch_target_predecoder.sv]
// x86 branch target predecoder, top level.
// Input register, decode and address adders, result register.
// Depends on xbtp_pkg.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+------------------------------------
//   req_     | in        | req_valid / req_ready | instr_addr, byte0..byte5
//   rsp_     | out       | rsp_valid / rsp_ready | flow/target/fallthrough fields
//
// One transfer per cycle sustained while rsp_ready stays high. After the req
// transfer the item sits in the input register, then moves into the result
// register and waits there until the rsp transfer takes it.
// Logic path: opcode decode, a small disp + len add, one 64-bit add per address.
// Reset (synchronous, active high) empties both stages; payload is not reset.
// A stall on rsp backs up one stage at a time; req_ready drops only when
// both stages hold items.
`timescale 1ns / 1ps
`default_nettype none

module x86_branch_target_predecoder (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [63:0] req_instr_addr,
   input  wire logic [7:0]  req_byte0,
   input  wire logic [7:0]  req_byte1,
   input  wire logic [7:0]  req_byte2,
   input  wire logic [7:0]  req_byte3,
   input  wire logic [7:0]  req_byte4,
   input  wire logic [7:0]  req_byte5,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_is_flow_control,
   output logic             rsp_target_valid,
   output logic [63:0]      rsp_target_addr,
   output logic             rsp_fallthrough_valid,
   output logic [63:0]      rsp_fallthrough_addr
);

   // ---------------------------------------------------------------
   // Stage 1: input register
   // ---------------------------------------------------------------
   logic        s1_valid_ff, s1_valid_in;
   logic [63:0] s1_addr_ff;
   logic [7:0]  s1_b0_ff, s1_b1_ff, s1_b2_ff, s1_b3_ff, s1_b4_ff, s1_b5_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   xbtp_pkg::rsp_type rsp_ff, rsp_in;

   logic s1_advance;   // stage 1 content moves into the result register
   logic req_xfer;

   assign s1_advance = !rsp_valid_ff || rsp_ready;
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_xfer   = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_ready) begin
         s1_valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_addr_ff <= req_instr_addr;
         s1_b0_ff   <= req_byte0;
         s1_b1_ff   <= req_byte1;
         s1_b2_ff   <= req_byte2;
         s1_b3_ff   <= req_byte3;
         s1_b4_ff   <= req_byte4;
         s1_b5_ff   <= req_byte5;
      end
   end

   // ---------------------------------------------------------------
   // Decode and address computation
   // ---------------------------------------------------------------
   logic        op_rel32_5;   // call / jmp near
   logic        op_rel32_6;   // 0F Jcc near
   logic        op_rel8;      // short jmp / Jcc
   logic        op_no_fall;   // call, jmp near, jmp short, ret
   logic        op_escape;
   logic [31:0] disp;         // displacement, sign-extended to 32 bits
   logic [2:0]  len;
   logic [33:0] offset;       // disp + len, signed
   logic [63:0] target_sum;

   assign op_escape  = (s1_b0_ff == xbtp_pkg::OP_ESCAPE);
   assign op_rel32_5 = (s1_b0_ff == xbtp_pkg::OP_CALL) || (s1_b0_ff == xbtp_pkg::OP_JMP_NEAR);
   assign op_rel32_6 = op_escape && xbtp_pkg::is_near_jcc(s1_b1_ff);
   assign op_rel8    = xbtp_pkg::is_short_branch(s1_b0_ff);
   assign op_no_fall = op_rel32_5 || (s1_b0_ff == xbtp_pkg::OP_JMP_SHORT) ||
                       (s1_b0_ff == xbtp_pkg::OP_RET);

   always_comb begin
      priority if (op_rel32_5) begin
         disp = {s1_b4_ff, s1_b3_ff, s1_b2_ff, s1_b1_ff};
         len  = xbtp_pkg::LEN_CALL;
      end else if (op_rel32_6) begin
         disp = {s1_b5_ff, s1_b4_ff, s1_b3_ff, s1_b2_ff};
         len  = xbtp_pkg::LEN_NEAR;
      end else begin
         disp = {{24{s1_b1_ff[7]}}, s1_b1_ff};
         len  = xbtp_pkg::LEN_SHORT;
      end
   end

   // Small add first, then one 64-bit add with the sign-extended offset.
   assign offset     = {{2{disp[31]}}, disp} + {31'd0, len};
   assign target_sum = s1_addr_ff + {{30{offset[33]}}, offset};

   always_comb begin
      rsp_in.is_flow_control   = op_rel32_5 || op_rel32_6 || op_rel8;
      rsp_in.target_valid      = rsp_in.is_flow_control;
      rsp_in.target_addr       = rsp_in.is_flow_control ? target_sum : 64'd0;
      rsp_in.fallthrough_valid = !op_no_fall;
      rsp_in.fallthrough_addr  = 64'd0;
      if (!op_no_fall) begin
         rsp_in.fallthrough_addr = s1_addr_ff + (op_escape ? 64'd6 : 64'd2);
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: result register
   // ---------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_is_flow_control   = rsp_ff.is_flow_control;
   assign rsp_target_valid      = rsp_ff.target_valid;
   assign rsp_target_addr       = rsp_ff.target_addr;
   assign rsp_fallthrough_valid = rsp_ff.fallthrough_valid;
   assign rsp_fallthrough_addr  = rsp_ff.fallthrough_addr;

`ifndef SYNTH
   // A held input item is never dropped while the result side stalls.
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_advance) |=> s1_valid_ff)
      else $error("stage 1 item lost during stall");

   // An item in stage 1 that advances shows up as a result next cycle.
   a_s1_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_advance) |=> rsp_valid)
      else $error("advanced item missing from result register");

   // Target fields agree with the flow-control flag.
   a_target: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_target_valid == rsp_is_flow_control) &&
                    (rsp_target_valid || (rsp_target_addr == 64'd0)))
      else $error("target fields inconsistent");

   // No fall-through means a zero fall-through address.
   a_fall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_fallthrough_valid) |-> (rsp_fallthrough_addr == 64'd0))
      else $error("fall-through address set without fall-through");
`endif

endmodule

`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for x86_branch_target_predecoder.
// Depends on xbtp_pkg and the predecoder RTL; compares each transfer against an
// in-line predecode model.
`timescale 1ns / 1ps

module tb;

   // 25 directed fetches plus this many random ones
   localparam int RANDOM_FETCHES = 1025;
   // Generous bound: worst gap plus worst rsp stall per item, several times over
   localparam int CYCLE_LIMIT    = 200000;
   // Idle tail after the last result is checked; the pipe has two stages
   localparam int TAIL_CYCLES    = 8;
   localparam int REPORT_LIMIT   = 10;

   // One fetch-stream entry: address plus the first six instruction bytes
   typedef struct packed {
      logic [63:0] addr;
      logic [7:0]  byte0;
      logic [7:0]  byte1;
      logic [7:0]  byte2;
      logic [7:0]  byte3;
      logic [7:0]  byte4;
      logic [7:0]  byte5;
   } fetch_type;

   // Clock and reset; every DUT input starts at a known value
   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [63:0] req_instr_addr = '0;
   logic [7:0]  req_byte0 = '0;
   logic [7:0]  req_byte1 = '0;
   logic [7:0]  req_byte2 = '0;
   logic [7:0]  req_byte3 = '0;
   logic [7:0]  req_byte4 = '0;
   logic [7:0]  req_byte5 = '0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_is_flow_control;
   logic        rsp_target_valid;
   logic [63:0] rsp_target_addr;
   logic        rsp_fallthrough_valid;
   logic [63:0] rsp_fallthrough_addr;

   // Fetches waiting to be driven, and predicted results waiting on rsp
   fetch_type          fetch_queue[$];
   xbtp_pkg::rsp_type  expected_rsp[$];

   int          total_fetches = 0;
   int          fetches_sent = 0;
   int          results_checked = 0;
   int          taken_seen = 0;
   int          fallthrough_seen = 0;
   int          mismatch_count = 0;
   int          cycle_count = 0;

   // Sender burst/gap state
   int          burst_left = 1;
   int          gap_left = 0;

   // Receiver stall pattern state
   int          ready_mode = 0;
   int          ready_left = 0;

   always #5 clock = ~clock;

   x86_branch_target_predecoder i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_instr_addr        (req_instr_addr),
      .req_byte0             (req_byte0),
      .req_byte1             (req_byte1),
      .req_byte2             (req_byte2),
      .req_byte3             (req_byte3),
      .req_byte4             (req_byte4),
      .req_byte5             (req_byte5),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_is_flow_control   (rsp_is_flow_control),
      .rsp_target_valid      (rsp_target_valid),
      .rsp_target_addr       (rsp_target_addr),
      .rsp_fallthrough_valid (rsp_fallthrough_valid),
      .rsp_fallthrough_addr  (rsp_fallthrough_addr)
   );

   // ---------------------------------------------------------------------------
   // Predecode model: classify the opcode, then form taken target and
   // fall-through. All sums are 64-bit and wrap naturally.
   // ---------------------------------------------------------------------------
   function automatic xbtp_pkg::rsp_type predecode_fetch(input fetch_type f);
      xbtp_pkg::rsp_type r;
      logic [31:0]       rel32_call;
      logic [31:0]       rel32_jcc;
      logic              near_jcc;
      logic              short_br;
      r          = '0;
      rel32_call = {f.byte4, f.byte3, f.byte2, f.byte1};
      rel32_jcc  = {f.byte5, f.byte4, f.byte3, f.byte2};
      case (f.byte1)
         xbtp_pkg::OP2_JB_N, xbtp_pkg::OP2_JE_N, xbtp_pkg::OP2_JNE_N,
         xbtp_pkg::OP2_JS_N, xbtp_pkg::OP2_JNS_N, xbtp_pkg::OP2_JL_N,
         xbtp_pkg::OP2_JGE_N, xbtp_pkg::OP2_JLE_N, xbtp_pkg::OP2_JG_N: near_jcc = 1'b1;
         default: near_jcc = 1'b0;
      endcase
      case (f.byte0)
         xbtp_pkg::OP_JMP_SHORT, xbtp_pkg::OP_JB_S, xbtp_pkg::OP_JE_S,
         xbtp_pkg::OP_JNE_S, xbtp_pkg::OP_JS_S, xbtp_pkg::OP_JNS_S,
         xbtp_pkg::OP_JL_S, xbtp_pkg::OP_JGE_S, xbtp_pkg::OP_JLE_S,
         xbtp_pkg::OP_JG_S: short_br = 1'b1;
         default: short_br = 1'b0;
      endcase

      // lengths: call/jmp near 5, 0F Jcc 6, short forms 2
      if (f.byte0 == xbtp_pkg::OP_CALL || f.byte0 == xbtp_pkg::OP_JMP_NEAR) begin
         r.target_valid = 1'b1;
         r.target_addr  = f.addr + 64'd5 + {{32{rel32_call[31]}}, rel32_call};
      end else if (f.byte0 == xbtp_pkg::OP_ESCAPE && near_jcc) begin
         r.target_valid = 1'b1;
         r.target_addr  = f.addr + 64'd6 + {{32{rel32_jcc[31]}}, rel32_jcc};
      end else if (short_br) begin
         r.target_valid = 1'b1;
         r.target_addr  = f.addr + 64'd2 + {{56{f.byte1[7]}}, f.byte1};
      end
      r.is_flow_control = r.target_valid;

      // unconditional transfers and ret never fall through; others use a
      // fixed +6 (0F escape) or +2, whatever the real length
      if (!(f.byte0 == xbtp_pkg::OP_CALL || f.byte0 == xbtp_pkg::OP_JMP_NEAR ||
            f.byte0 == xbtp_pkg::OP_JMP_SHORT || f.byte0 == xbtp_pkg::OP_RET)) begin
         r.fallthrough_valid = 1'b1;
         r.fallthrough_addr  = f.addr +
                               ((f.byte0 == xbtp_pkg::OP_ESCAPE) ? 64'd6 : 64'd2);
      end
      return r;
   endfunction

   // Single-byte opcodes with a target: indexes 0..2 unconditional, 3..11 Jcc
   function automatic logic [7:0] flow_opcode(input int unsigned idx);
      case (idx)
         0:       return xbtp_pkg::OP_CALL;
         1:       return xbtp_pkg::OP_JMP_NEAR;
         2:       return xbtp_pkg::OP_JMP_SHORT;
         3:       return xbtp_pkg::OP_JB_S;
         4:       return xbtp_pkg::OP_JE_S;
         5:       return xbtp_pkg::OP_JNE_S;
         6:       return xbtp_pkg::OP_JS_S;
         7:       return xbtp_pkg::OP_JNS_S;
         8:       return xbtp_pkg::OP_JL_S;
         9:       return xbtp_pkg::OP_JGE_S;
         10:      return xbtp_pkg::OP_JLE_S;
         default: return xbtp_pkg::OP_JG_S;
      endcase
   endfunction

   // Second bytes of the listed 0F near Jcc forms
   function automatic logic [7:0] near_jcc_opcode(input int unsigned idx);
      case (idx)
         0:       return xbtp_pkg::OP2_JB_N;
         1:       return xbtp_pkg::OP2_JE_N;
         2:       return xbtp_pkg::OP2_JNE_N;
         3:       return xbtp_pkg::OP2_JS_N;
         4:       return xbtp_pkg::OP2_JNS_N;
         5:       return xbtp_pkg::OP2_JL_N;
         6:       return xbtp_pkg::OP2_JGE_N;
         7:       return xbtp_pkg::OP2_JLE_N;
         default: return xbtp_pkg::OP2_JG_N;
      endcase
   endfunction

   function automatic fetch_type make_fetch(input logic [63:0] addr,
                                            input logic [7:0] b0, input logic [7:0] b1,
                                            input logic [7:0] b2, input logic [7:0] b3,
                                            input logic [7:0] b4, input logic [7:0] b5);
      fetch_type f;
      f.addr  = addr;
      f.byte0 = b0;
      f.byte1 = b1;
      f.byte2 = b2;
      f.byte3 = b3;
      f.byte4 = b4;
      f.byte5 = b5;
      return f;
   endfunction

   // Append one fetch to the tail of the pending queue
   function automatic void enqueue_fetch(input fetch_type f);
      fetch_queue.insert(fetch_queue.size(), f);
   endfunction

   function automatic logic [63:0] random_addr();
      logic [63:0] a;
      a = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0:       a = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 15));
         1:       a = 64'($urandom_range(0, 15));
         default: ;
      endcase
      return a;
   endfunction

   // Mostly branch forms with random content, plus escapes, ret and noise
   function automatic fetch_type random_fetch();
      fetch_type   f;
      int unsigned pick;
      f = make_fetch(random_addr(), 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), 8'($urandom), 8'($urandom));
      pick = $urandom_range(0, 19);
      if (pick < 10) begin
         f.byte0 = flow_opcode($urandom_range(0, 11));
      end else if (pick < 13) begin
         f.byte0 = xbtp_pkg::OP_ESCAPE;
         f.byte1 = near_jcc_opcode($urandom_range(0, 8));
      end else if (pick < 15) begin
         f.byte0 = xbtp_pkg::OP_ESCAPE;
      end else if (pick == 15) begin
         f.byte0 = xbtp_pkg::OP_RET;
      end
      // now and then push bytes 2..5, the rel32 of the 0F near Jcc form, to its sign extremes
      case ($urandom_range(0, 7))
         0: begin
            f.byte2 = 8'h00; f.byte3 = 8'h00; f.byte4 = 8'h00; f.byte5 = 8'h80;
         end
         1: begin
            f.byte2 = 8'hFF; f.byte3 = 8'hFF; f.byte4 = 8'hFF; f.byte5 = 8'h7F;
         end
         default: ;
      endcase
      return f;
   endfunction

   task automatic report_error(input string what, input xbtp_pkg::rsp_type want,
                               input xbtp_pkg::rsp_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("%0t: %s", $realtime, what);
         $display("   exp flow=%b tv=%b tgt=%h fv=%b fall=%h", want.is_flow_control,
                  want.target_valid, want.target_addr, want.fallthrough_valid,
                  want.fallthrough_addr);
         $display("   got flow=%b tv=%b tgt=%h fv=%b fall=%h", got.is_flow_control,
                  got.target_valid, got.target_addr, got.fallthrough_valid,
                  got.fallthrough_addr);
      end
   endtask

   // ---------------------------------------------------------------------------
   // Driver: pulls from fetch_queue in bursts separated by random gaps. The
   // prediction is taken from the pins at the edge where the transfer
   // happens, so it always matches what the DUT actually saw.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : req_driver
      logic      next_valid;
      fetch_type f;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         next_valid = req_valid;
         if (req_valid && req_ready) begin
            f = make_fetch(req_instr_addr, req_byte0, req_byte1, req_byte2,
                           req_byte3, req_byte4, req_byte5);
            expected_rsp.insert(expected_rsp.size(), predecode_fetch(f));
            fetches_sent++;
            next_valid = 1'b0;
         end
         // valid only drops after a transfer, never while an item is waiting
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
            end else if (fetch_queue.size() > 0) begin
               f = fetch_queue.pop_front();
               req_instr_addr <= f.addr;
               req_byte0      <= f.byte0;
               req_byte1      <= f.byte1;
               req_byte2      <= f.byte2;
               req_byte3      <= f.byte3;
               req_byte4      <= f.byte4;
               req_byte5      <= f.byte5;
               next_valid = 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 48);
                  // a quarter of the bursts run straight into the next one
                  gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end
         end
         req_valid <= next_valid;
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: checks each rsp transfer against the oldest prediction and
   // runs its own rsp_ready pattern (full speed, coin flip, mostly stalled,
   // and blocks of eight).
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_monitor
      xbtp_pkg::rsp_type got;
      xbtp_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.is_flow_control   = rsp_is_flow_control;
            got.target_valid      = rsp_target_valid;
            got.target_addr       = rsp_target_addr;
            got.fallthrough_valid = rsp_fallthrough_valid;
            got.fallthrough_addr  = rsp_fallthrough_addr;
            if (expected_rsp.size() == 0) begin
               report_error("rsp transfer with nothing predicted", '0, got);
            end else begin
               want = expected_rsp.pop_front();
               results_checked++;
               if (want.target_valid) taken_seen++;
               if (want.fallthrough_valid) fallthrough_seen++;
               if (got.is_flow_control !== want.is_flow_control ||
                   got.target_valid !== want.target_valid ||
                   got.target_addr !== want.target_addr ||
                   got.fallthrough_valid !== want.fallthrough_valid ||
                   got.fallthrough_addr !== want.fallthrough_addr) begin
                  report_error("predecode mismatch", want, got);
               end
            end
         end

         if (ready_left == 0) begin
            ready_mode <= $urandom_range(0, 3);
            ready_left <= $urandom_range(8, 64);
         end else begin
            ready_left <= ready_left - 1;
         end
         case (ready_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= 1'($urandom_range(0, 1));
            2:       rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= ready_left[3];
         endcase
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d of %0d fetches sent, %0d checked",
                  cycle_count, fetches_sent, total_fetches, results_checked);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus and end of test
   // ---------------------------------------------------------------------------
   initial begin : stimulus
      logic [63:0] a;
      // call from address 0 with the most negative rel32: target wraps low
      enqueue_fetch(make_fetch(64'h0, xbtp_pkg::OP_CALL, 8'h00, 8'h00, 8'h00,
                               8'h80, 8'h5A));
      // jmp near from the top of the address space, largest rel32: wraps high
      enqueue_fetch(make_fetch(64'hFFFF_FFFF_FFFF_FFFF, xbtp_pkg::OP_JMP_NEAR,
                               8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hA5));
      // jmp short backward from 0
      enqueue_fetch(make_fetch(64'h0, xbtp_pkg::OP_JMP_SHORT, 8'h80, 8'h00, 8'h00,
                               8'h00, 8'h00));
      // ret: neither target nor fall-through
      enqueue_fetch(make_fetch(random_addr(), xbtp_pkg::OP_RET, 8'($urandom),
                               8'($urandom), 8'($urandom), 8'($urandom),
                               8'($urandom)));
      // every short Jcc, rel8 alternating between its sign extremes
      for (int unsigned i = 3; i < 12; i++) begin
         enqueue_fetch(make_fetch(random_addr(), flow_opcode(i),
                                  i[0] ? 8'h80 : 8'h7F, 8'($urandom),
                                  8'($urandom), 8'($urandom), 8'($urandom)));
      end
      // every 0F near Jcc, rel32 alternating between its sign extremes
      for (int unsigned i = 0; i < 9; i++) begin
         a = i[0] ? 64'hFFFF_FFFF_FFFF_FFF0 : 64'h8;
         if (i[0]) begin
            enqueue_fetch(make_fetch(a, xbtp_pkg::OP_ESCAPE, near_jcc_opcode(i),
                                     8'hFF, 8'hFF, 8'hFF, 8'h7F));
         end else begin
            enqueue_fetch(make_fetch(a, xbtp_pkg::OP_ESCAPE, near_jcc_opcode(i),
                                     8'h00, 8'h00, 8'h00, 8'h80));
         end
      end
      // 0F escape that is not a listed branch: +6 fall-through wraps
      enqueue_fetch(make_fetch(64'hFFFF_FFFF_FFFF_FFFC, xbtp_pkg::OP_ESCAPE, 8'h00,
                               8'h00, 8'h00, 8'h00, 8'h00));
      // plain non-branch bytes at the field extremes
      enqueue_fetch(make_fetch(64'h0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      enqueue_fetch(make_fetch(64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 8'hFF, 8'hFF,
                               8'hFF, 8'hFF, 8'hFF));

      for (int i = 0; i < RANDOM_FETCHES; i++) begin
         enqueue_fetch(random_fetch());
      end
      total_fetches = fetch_queue.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // sample away from the active edge so the driver's updates have landed
      while (fetches_sent < total_fetches) @(negedge clock);
      while (expected_rsp.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("%0d fetches sent, %0d results checked:", fetches_sent, results_checked);
      $display("   %0d with taken target, %0d with fall-through", taken_seen,
               fallthrough_seen);
      $display("%0d mismatches, %0d predictions left over", mismatch_count,
               expected_rsp.size());
      if (mismatch_count == 0 && expected_rsp.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
